// ----- hw/rtl/rlt_pkg.sv -----
// Package for the rekey limit tracker: operation and decision codes, payload
// structs, policy reset values and small compare helpers.
// No dependencies; every module of the block imports it.
package rlt_pkg;

  localparam int unsigned CNT_W = 64;
  localparam int unsigned PKT_W = 33;

  // Largest hard packet limit that the policy accepts.
  localparam logic [PKT_W-1:0] HARD_PACKET_CAP = 33'h1_0000_0000;

  // Policy register values after reset.
  localparam logic [CNT_W-1:0] RST_BYTE_LIMIT    = 64'd1073741824;
  localparam logic [CNT_W-1:0] RST_BLOCK_LIMIT   = 64'd4294967296;
  localparam logic [CNT_W-1:0] RST_TIME_LIMIT_MS = 64'd3600000;
  localparam logic [PKT_W-1:0] RST_SEND_PKT_LIMIT = 33'd2147483648;
  localparam logic [PKT_W-1:0] RST_RECV_PKT_LIMIT = 33'd2147483648;
  localparam logic [PKT_W-1:0] RST_HARD_PKT_LIMIT = HARD_PACKET_CAP;

  typedef enum logic [2:0] {
    OP_CHECK      = 3'd0,
    OP_RES_SEND   = 3'd1,
    OP_RES_RECV   = 3'd2,
    OP_RESET_ALL  = 3'd3,
    OP_RESET_SEND = 3'd4,
    OP_RESET_RECV = 3'd5,
    OP_REQUEST    = 3'd6,
    OP_COMPLETE   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    DEC_NONE      = 2'd0,
    DEC_RECOMMEND = 2'd1,
    DEC_REQUIRED  = 2'd2
  } decision_e;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_ARG_ERR = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    CFG_BYTE_LIMIT     = 3'd0,
    CFG_BLOCK_LIMIT    = 3'd1,
    CFG_TIME_LIMIT_MS  = 3'd2,
    CFG_SEND_PKT_LIMIT = 3'd3,
    CFG_RECV_PKT_LIMIT = 3'd4,
    CFG_HARD_PKT_LIMIT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] now_ms;
    logic [CNT_W-1:0] wire_bytes;
    logic [CNT_W-1:0] cipher_blocks;
  } rlt_in_t;

  typedef struct packed {
    status_e   status;
    decision_e decision;
  } rlt_out_t;

  // Current policy as seen by the counters and the control.
  typedef struct packed {
    logic [CNT_W-1:0] byte_limit;
    logic [CNT_W-1:0] block_limit;
    logic [CNT_W-1:0] time_limit_ms;
    logic [PKT_W-1:0] send_pkt_limit;
    logic [PKT_W-1:0] recv_pkt_limit;
    logic [PKT_W-1:0] hard_pkt_limit;
    logic             ok;
  } policy_t;

  // Per-direction commands from the control.
  typedef struct packed {
    logic clear;
    logic reserve;
  } dir_ctrl_t;

  // Per-direction limit status: before and after a counted reservation.
  typedef struct packed {
    logic hard_hit;
    logic soft_hit;
    logic after_hit;
  } dir_stat_t;

  // A soft limit of zero is disabled.
  function automatic logic hit64(input logic [CNT_W-1:0] v, input logic [CNT_W-1:0] lim);
    return (lim != '0) && (v >= lim);
  endfunction

  function automatic logic hit33(input logic [PKT_W-1:0] v, input logic [PKT_W-1:0] lim);
    return (lim != '0) && (v >= lim);
  endfunction

endpackage

// ----- hw/rtl/rlt_policy.sv -----
// Policy registers of the rekey limit tracker and the policy validity check.
// Depends on rlt_pkg.
module rlt_policy
  import rlt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  output policy_t          policy_o
);

  logic [CNT_W-1:0] byte_limit_q, block_limit_q, time_limit_q;
  logic [PKT_W-1:0] send_lim_q, recv_lim_q, hard_lim_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q  <= RST_BYTE_LIMIT;
      block_limit_q <= RST_BLOCK_LIMIT;
      time_limit_q  <= RST_TIME_LIMIT_MS;
      send_lim_q    <= RST_SEND_PKT_LIMIT;
      recv_lim_q    <= RST_RECV_PKT_LIMIT;
      hard_lim_q    <= RST_HARD_PKT_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BYTE_LIMIT:     byte_limit_q  <= cfg_data_i;
        CFG_BLOCK_LIMIT:    block_limit_q <= cfg_data_i;
        CFG_TIME_LIMIT_MS:  time_limit_q  <= cfg_data_i;
        CFG_SEND_PKT_LIMIT: send_lim_q    <= cfg_data_i[PKT_W-1:0];
        CFG_RECV_PKT_LIMIT: recv_lim_q    <= cfg_data_i[PKT_W-1:0];
        CFG_HARD_PKT_LIMIT: hard_lim_q    <= cfg_data_i[PKT_W-1:0];
        default: ;
      endcase
    end
  end

  // The hard limit must be in range and each enabled soft packet limit
  // must not exceed it.
  always_comb begin
    policy_o.byte_limit     = byte_limit_q;
    policy_o.block_limit    = block_limit_q;
    policy_o.time_limit_ms  = time_limit_q;
    policy_o.send_pkt_limit = send_lim_q;
    policy_o.recv_pkt_limit = recv_lim_q;
    policy_o.hard_pkt_limit = hard_lim_q;
    policy_o.ok = (hard_lim_q != '0) && (hard_lim_q <= HARD_PACKET_CAP) &&
                  ((send_lim_q == '0) || (send_lim_q <= hard_lim_q)) &&
                  ((recv_lim_q == '0) || (recv_lim_q <= hard_lim_q));
  end

endmodule

// ----- hw/rtl/rlt_dir.sv -----
// Usage counters of one direction: packets, bytes, cipher blocks and the key
// start time, with the limit compares before and after a reservation.
// Depends on rlt_pkg.
module rlt_dir
  import rlt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dir_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0] now_ms_i,
  input  logic [CNT_W-1:0] wire_bytes_i,
  input  logic [CNT_W-1:0] cipher_blocks_i,
  input  policy_t          policy_i,
  input  logic [PKT_W-1:0] pkt_limit_i,
  output dir_stat_t        stat_o
);

  logic [PKT_W-1:0] pkt_q, pkt_d, pkt_inc;
  logic [CNT_W-1:0] bytes_q, bytes_d, blocks_q, blocks_d, start_q, start_d;
  logic [CNT_W-1:0] age, bytes_sat, blocks_sat;
  logic [CNT_W:0]   bytes_sum, blocks_sum;
  logic             age_hit;

  // Key age; a start time in the future counts as zero age.
  assign age     = (now_ms_i >= start_q) ? (now_ms_i - start_q) : '0;
  assign age_hit = hit64(age, policy_i.time_limit_ms);

  // Saturating sums for a counted reservation.
  assign bytes_sum  = {1'b0, bytes_q} + {1'b0, wire_bytes_i};
  assign blocks_sum = {1'b0, blocks_q} + {1'b0, cipher_blocks_i};
  assign bytes_sat  = bytes_sum[CNT_W] ? '1 : bytes_sum[CNT_W-1:0];
  assign blocks_sat = blocks_sum[CNT_W] ? '1 : blocks_sum[CNT_W-1:0];
  assign pkt_inc    = pkt_q + PKT_W'(1);

  // Limit status with the present counts and with the reserved packet added.
  always_comb begin
    stat_o.hard_hit  = pkt_q >= policy_i.hard_pkt_limit;
    stat_o.soft_hit  = age_hit ||
                       hit64(bytes_q, policy_i.byte_limit) ||
                       hit64(blocks_q, policy_i.block_limit) ||
                       hit33(pkt_q, pkt_limit_i);
    stat_o.after_hit = age_hit ||
                       (pkt_inc >= policy_i.hard_pkt_limit) ||
                       hit64(bytes_sat, policy_i.byte_limit) ||
                       hit64(blocks_sat, policy_i.block_limit) ||
                       hit33(pkt_inc, pkt_limit_i);
  end

  // Counter updates.
  always_comb begin
    pkt_d    = pkt_q;
    bytes_d  = bytes_q;
    blocks_d = blocks_q;
    start_d  = start_q;
    if (ctrl_i.clear) begin
      pkt_d    = '0;
      bytes_d  = '0;
      blocks_d = '0;
      start_d  = now_ms_i;
    end else if (ctrl_i.reserve) begin
      pkt_d    = pkt_inc;
      bytes_d  = bytes_sat;
      blocks_d = blocks_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q    <= '0;
      bytes_q  <= '0;
      blocks_q <= '0;
      start_q  <= '0;
    end else begin
      pkt_q    <= pkt_d;
      bytes_q  <= bytes_d;
      blocks_q <= blocks_d;
      start_q  <= start_d;
    end
  end

endmodule

// ----- hw/rtl/rlt_ctrl.sv -----
// Request handshake, input and result registers, operation decode, the
// manual rekey flag and the decision of the rekey limit tracker.
// Depends on rlt_pkg.
module rlt_ctrl
  import rlt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rlt_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rlt_out_t  out_data_o,
  input  logic      policy_ok_i,
  input  dir_stat_t send_stat_i,
  input  dir_stat_t recv_stat_i,
  output dir_ctrl_t send_ctrl_o,
  output dir_ctrl_t recv_ctrl_o,
  output rlt_in_t   item_o
);

  logic      in_vld_q, out_vld_q, advance, fire;
  logic      req_flag_q, req_flag_d, required, pending;
  rlt_in_t   item_q;
  rlt_out_t  out_q, result;

  // The result register moves when empty or taken; the input register
  // holds while the result register is blocked.
  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign item_o      = item_q;

  assign required = send_stat_i.hard_hit || recv_stat_i.hard_hit;
  assign pending  = req_flag_q || send_stat_i.soft_hit || recv_stat_i.soft_hit;

  // Decode of the registered request.
  always_comb begin
    result          = '{status: ST_OK, decision: DEC_NONE};
    send_ctrl_o     = '0;
    recv_ctrl_o     = '0;
    req_flag_d      = req_flag_q;
    if (!policy_ok_i) begin
      result.status = ST_ARG_ERR;
    end else begin
      case (item_q.op)
        OP_CHECK: begin
          result.decision = required ? DEC_REQUIRED : (pending ? DEC_RECOMMEND : DEC_NONE);
        end
        OP_RES_SEND: begin
          if (required) begin
            result.decision = DEC_REQUIRED;
          end else begin
            send_ctrl_o.reserve = fire;
            result.decision = (req_flag_q || send_stat_i.after_hit || recv_stat_i.soft_hit)
                              ? DEC_RECOMMEND : DEC_NONE;
          end
        end
        OP_RES_RECV: begin
          if (required) begin
            result.decision = DEC_REQUIRED;
          end else begin
            recv_ctrl_o.reserve = fire;
            result.decision = (req_flag_q || recv_stat_i.after_hit || send_stat_i.soft_hit)
                              ? DEC_RECOMMEND : DEC_NONE;
          end
        end
        OP_RESET_ALL: begin
          send_ctrl_o.clear = fire;
          recv_ctrl_o.clear = fire;
          if (fire) req_flag_d = 1'b0;
        end
        OP_RESET_SEND: send_ctrl_o.clear = fire;
        OP_RESET_RECV: recv_ctrl_o.clear = fire;
        OP_REQUEST: begin
          if (fire) req_flag_d = 1'b1;
        end
        OP_COMPLETE: begin
          if (fire) req_flag_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      req_flag_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (advance) out_vld_q <= in_vld_q;
      req_flag_q <= req_flag_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) item_q <= in_data_i;
    if (fire) out_q <= result;
  end

endmodule

// ----- hw/rtl/rekey_limit_tracker.sv -----
// Rekey limit tracker: per-direction key usage counters and rekey decision.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result is not stalled; the counters
// update in the same cycle as the decision, so each request sees all earlier ones.
// Reset: counters, start times and the request flag clear; policy takes defaults.
module rekey_limit_tracker
  import rlt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rlt_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rlt_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  policy_t   policy;
  dir_ctrl_t send_ctrl, recv_ctrl;
  dir_stat_t send_stat, recv_stat;
  rlt_in_t   item;

  // Policy registers.
  rlt_policy u_policy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .policy_o    (policy)
  );

  // Send direction counters.
  rlt_dir u_send (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (send_ctrl),
    .now_ms_i        (item.now_ms),
    .wire_bytes_i    (item.wire_bytes),
    .cipher_blocks_i (item.cipher_blocks),
    .policy_i        (policy),
    .pkt_limit_i     (policy.send_pkt_limit),
    .stat_o          (send_stat)
  );

  // Receive direction counters.
  rlt_dir u_recv (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (recv_ctrl),
    .now_ms_i        (item.now_ms),
    .wire_bytes_i    (item.wire_bytes),
    .cipher_blocks_i (item.cipher_blocks),
    .policy_i        (policy),
    .pkt_limit_i     (policy.recv_pkt_limit),
    .stat_o          (recv_stat)
  );

  // Handshake, decode and decision.
  rlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .policy_ok_i (policy.ok),
    .send_stat_i (send_stat),
    .recv_stat_i (recv_stat),
    .send_ctrl_o (send_ctrl),
    .recv_ctrl_o (recv_ctrl),
    .item_o      (item)
  );

endmodule

// ----- hw/rtl/rlt_checker.sv -----
// Port-level checks for the rekey limit tracker, bound to the top level.
// Depends on rlt_pkg.
module rlt_checker
  import rlt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rlt_out_t out_data_o
);

  // A blocked result stays and holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The input only stalls behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // An accepted request shows its result after the input and result registers unless blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !(out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result missing after accepted request");

  // An argument error carries no decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_ARG_ERR) |-> out_data_o.decision == DEC_NONE)
    else $error("decision given with argument error");

endmodule

bind rekey_limit_tracker rlt_checker u_rlt_checker (.*);

// ----- test/rekey_limit_tracker_test.sv -----
// Self-checking testbench for rekey_limit_tracker. It drives requests and policy
// writes, predicts each result, and compares results in order of arrival.
// Depends on rlt_pkg and the rekey_limit_tracker RTL only.
module rekey_limit_tracker_test;
  import rlt_pkg::*;

  // Register indexes that the policy does not use; writes to them are ignored.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned RUN_LIMIT   = 2000000;
  localparam int unsigned PHASES      = 17;
  localparam int unsigned PHASE_ITEMS = 50;

  // Tracks key usage the way the block should, and holds the results still due.
  class rekey_usage_scoreboard;
    logic [CNT_W-1:0] byte_lim, block_lim, age_lim;
    logic [PKT_W-1:0] send_pkt_lim, recv_pkt_lim, hard_pkt_lim;
    logic [PKT_W-1:0] tx_pkts, rx_pkts;
    logic [CNT_W-1:0] tx_bytes, tx_blocks, rx_bytes, rx_blocks;
    logic [CNT_W-1:0] tx_start, rx_start;
    bit               rekey_pending;
    rlt_out_t         due_q[$];
    int unsigned      mismatches;

    function new();
      byte_lim      = RST_BYTE_LIMIT;
      block_lim     = RST_BLOCK_LIMIT;
      age_lim       = RST_TIME_LIMIT_MS;
      send_pkt_lim  = RST_SEND_PKT_LIMIT;
      recv_pkt_lim  = RST_RECV_PKT_LIMIT;
      hard_pkt_lim  = RST_HARD_PKT_LIMIT;
      clear_tx('0);
      clear_rx('0);
      rekey_pending = 1'b0;
      mismatches    = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void write_policy(logic [2:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        CFG_BYTE_LIMIT:     byte_lim     = val;
        CFG_BLOCK_LIMIT:    block_lim    = val;
        CFG_TIME_LIMIT_MS:  age_lim      = val;
        CFG_SEND_PKT_LIMIT: send_pkt_lim = val[PKT_W-1:0];
        CFG_RECV_PKT_LIMIT: recv_pkt_lim = val[PKT_W-1:0];
        CFG_HARD_PKT_LIMIT: hard_pkt_lim = val[PKT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit policy_valid();
      if (hard_pkt_lim == '0 || hard_pkt_lim > HARD_PACKET_CAP) return 1'b0;
      if (send_pkt_lim != '0 && send_pkt_lim > hard_pkt_lim) return 1'b0;
      if (recv_pkt_lim != '0 && recv_pkt_lim > hard_pkt_lim) return 1'b0;
      return 1'b1;
    endfunction

    function void clear_tx(logic [CNT_W-1:0] now);
      tx_pkts   = '0;
      tx_bytes  = '0;
      tx_blocks = '0;
      tx_start  = now;
    endfunction

    function void clear_rx(logic [CNT_W-1:0] now);
      rx_pkts   = '0;
      rx_bytes  = '0;
      rx_blocks = '0;
      rx_start  = now;
    endfunction

    function logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // A limit of zero never triggers.
    function bit reached(logic [CNT_W-1:0] v, logic [CNT_W-1:0] lim);
      return (lim != '0) && (v >= lim);
    endfunction

    function decision_e rekey_decision(logic [CNT_W-1:0] now);
      logic [CNT_W-1:0] tx_age, rx_age;
      // A start time in the future counts as no age at all.
      tx_age = (now >= tx_start) ? now - tx_start : '0;
      rx_age = (now >= rx_start) ? now - rx_start : '0;
      if (tx_pkts >= hard_pkt_lim || rx_pkts >= hard_pkt_lim) return DEC_REQUIRED;
      if (rekey_pending ||
          reached(tx_age, age_lim) || reached(rx_age, age_lim) ||
          reached(tx_bytes, byte_lim) || reached(rx_bytes, byte_lim) ||
          reached(tx_blocks, block_lim) || reached(rx_blocks, block_lim) ||
          reached({31'b0, tx_pkts}, {31'b0, send_pkt_lim}) ||
          reached({31'b0, rx_pkts}, {31'b0, recv_pkt_lim}))
        return DEC_RECOMMEND;
      return DEC_NONE;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(rlt_in_t req);
      rlt_out_t want;
      want.status   = ST_OK;
      want.decision = DEC_NONE;
      if (!policy_valid()) begin
        want.status = ST_ARG_ERR;
      end else begin
        case (req.op)
          OP_CHECK: want.decision = rekey_decision(req.now_ms);
          OP_RES_SEND, OP_RES_RECV: begin
            want.decision = rekey_decision(req.now_ms);
            // A packet reserved while a rekey is required is not counted.
            if (want.decision != DEC_REQUIRED) begin
              if (req.op == OP_RES_SEND) begin
                tx_pkts   = tx_pkts + 1'b1;
                tx_bytes  = sat_sum(tx_bytes, req.wire_bytes);
                tx_blocks = sat_sum(tx_blocks, req.cipher_blocks);
              end else begin
                rx_pkts   = rx_pkts + 1'b1;
                rx_bytes  = sat_sum(rx_bytes, req.wire_bytes);
                rx_blocks = sat_sum(rx_blocks, req.cipher_blocks);
              end
              want.decision = rekey_decision(req.now_ms);
              if (want.decision == DEC_REQUIRED) want.decision = DEC_RECOMMEND;
            end
          end
          OP_RESET_ALL: begin
            clear_tx(req.now_ms);
            clear_rx(req.now_ms);
            rekey_pending = 1'b0;
          end
          OP_RESET_SEND: clear_tx(req.now_ms);
          OP_RESET_RECV: clear_rx(req.now_ms);
          OP_REQUEST:    rekey_pending = 1'b1;
          default:       rekey_pending = 1'b0;
        endcase
      end
      due_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(rlt_out_t got);
      rlt_out_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d decision %0d",
                                  got.status, got.decision));
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.decision !== want.decision)
        report_mismatch($sformatf("decision %0d, expected %0d",
                                  got.decision, want.decision));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  rlt_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  rlt_out_t         out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i;
  logic [CNT_W-1:0] cfg_data_i;

  rekey_usage_scoreboard usage_sb;

  // Per-phase stimulus shape.
  bit               quiet_phase;
  int unsigned      amount_scale;
  int unsigned      age_step;
  logic [CNT_W-1:0] clock_ms;

  rekey_limit_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Result side: check each accepted result, then stall for a random while unless the phase is quiet.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        usage_sb.check_result(out_data_o);
        hold = quiet_phase ? 0 : $urandom_range(0, 3);
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [CNT_W-1:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  // Bytes or blocks of one packet: mostly small, sometimes huge.
  function automatic logic [CNT_W-1:0] usage_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return {CNT_W{1'b1}};
    if (r < 12) return rand_wide();
    if (r < 20) return '0;
    return CNT_W'($urandom_range(0, amount_scale));
  endfunction

  // Time mostly moves forward; now and then it jumps or falls back.
  function automatic logic [CNT_W-1:0] pick_now();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return {CNT_W{1'b1}};
    if (r < 6) return rand_wide();
    if (r < 10) return clock_ms - CNT_W'($urandom_range(0, 500));
    clock_ms = clock_ms + CNT_W'($urandom_range(0, age_step));
    return clock_ms;
  endfunction

  function automatic op_e pick_op();
    int unsigned r;
    logic [2:0]  any_op;
    r = $urandom_range(0, 99);
    any_op = 3'($urandom_range(0, 7));
    if (r < 30) return OP_RES_SEND;
    if (r < 60) return OP_RES_RECV;
    if (r < 70) return OP_CHECK;
    if (r < 75) return OP_RESET_SEND;
    if (r < 80) return OP_RESET_RECV;
    if (r < 84) return OP_RESET_ALL;
    if (r < 90) return OP_REQUEST;
    if (r < 95) return OP_COMPLETE;
    return op_e'(any_op);
  endfunction

  function automatic logic [PKT_W-1:0] pick_hard();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 33'd1;
    if (r < 55) return PKT_W'($urandom_range(2, 40));
    if (r < 63) return HARD_PACKET_CAP;
    if (r < 73) return {1'b0, $urandom()} + 33'd1;
    if (r < 77) return '0;
    if (r < 81) return HARD_PACKET_CAP + 33'd1;
    if (r < 85) return {PKT_W{1'b1}};
    return PKT_W'($urandom_range(41, 300));
  endfunction

  function automatic logic [PKT_W-1:0] pick_soft_pkt(logic [PKT_W-1:0] hard);
    int unsigned      r;
    logic [CNT_W-1:0] span;
    r = $urandom_range(0, 99);
    span = (hard == '0) ? 64'd1 : {31'b0, hard};
    if (r < 20) return '0;
    if (r < 35) return hard;
    if (r < 42) return hard + 33'd1;
    if (r < 47) return {PKT_W{1'b1}};
    return 33'd1 + 33'(rand_wide() % span);
  endfunction

  function automatic logic [CNT_W-1:0] pick_limit(int unsigned small_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 65) return CNT_W'($urandom_range(1, small_max));
    if (r < 75) return {CNT_W{1'b1}};
    return rand_wide();
  endfunction

  // Packet limits are 33 bits wide; the upper bits of the write are junk at times.
  function automatic logic [CNT_W-1:0] pad_pkt(logic [PKT_W-1:0] v);
    logic [30:0] junk;
    junk = 31'($urandom());
    return $urandom_range(0, 1) ? {junk, v} : {31'b0, v};
  endfunction

  task automatic write_register(logic [2:0] idx, logic [CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    usage_sb.write_policy(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One request: an optional gap, then hold it until the block takes it.
  task automatic drive_request(rlt_in_t req);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    usage_sb.note_request(req);
  endtask

  task automatic issue(op_e op, logic [CNT_W-1:0] now, logic [CNT_W-1:0] wb,
                       logic [CNT_W-1:0] cb);
    rlt_in_t req;
    req.op            = op;
    req.now_ms        = now;
    req.wire_bytes    = wb;
    req.cipher_blocks = cb;
    drive_request(req);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (usage_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // New policy for a phase; registers are kept at random unless all are forced.
  task automatic set_policy(bit all_regs);
    logic [PKT_W-1:0] hard;
    hard = pick_hard();
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_BYTE_LIMIT, pick_limit(5000));
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_BLOCK_LIMIT, pick_limit(5000));
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_TIME_LIMIT_MS, pick_limit(3000));
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_HARD_PKT_LIMIT, pad_pkt(hard));
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_SEND_PKT_LIMIT, pad_pkt(pick_soft_pkt(hard)));
    if (all_regs || $urandom_range(0, 3) != 0)
      write_register(CFG_RECV_PKT_LIMIT, pad_pkt(pick_soft_pkt(hard)));
    if ($urandom_range(0, 9) == 0)
      write_register($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, rand_wide());
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [2:0] op_code;
    usage_sb     = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_BYTE_LIMIT;
    cfg_data_i   = '0;
    quiet_phase  = 1'b0;
    amount_scale = 100;
    age_step     = 100;
    clock_ms     = 64'd2000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset policy: manual request, saturation and key age.
    issue(OP_CHECK, '0, '0, '0);
    issue(OP_REQUEST, 64'd5, '0, '0);
    issue(OP_CHECK, 64'd5, '0, '0);
    issue(OP_COMPLETE, 64'd6, '0, '0);
    issue(OP_RES_SEND, 64'd10, {CNT_W{1'b1}}, '0);
    issue(OP_RES_SEND, 64'd11, {CNT_W{1'b1}}, {CNT_W{1'b1}});
    issue(OP_RES_RECV, 64'd12, 64'd1, {CNT_W{1'b1}});
    issue(OP_RESET_ALL, 64'd1000, {CNT_W{1'b1}}, {CNT_W{1'b1}});
    // Time before the start time counts as zero age.
    issue(OP_CHECK, 64'd500, '0, '0);
    issue(OP_CHECK, 64'd1000 + RST_TIME_LIMIT_MS, '0, '0);
    issue(OP_RESET_SEND, {CNT_W{1'b1}}, '0, '0);
    issue(OP_RESET_RECV, {CNT_W{1'b1}}, '0, '0);
    issue(OP_CHECK, '0, '0, '0);
    issue(OP_CHECK, {CNT_W{1'b1}}, '0, '0);
    settle();

    // Hard limit of one under soft limits above it: every operation is refused.
    write_register(CFG_HARD_PKT_LIMIT, 64'd1);
    for (int k = 0; k < 8; k++) begin
      op_code = 3'(k);
      issue(op_e'(op_code), 64'd3000, 64'd7, 64'd7);
    end
    settle();

    // Valid again: one packet reaches the hard limit, later ones are refused.
    write_register(CFG_SEND_PKT_LIMIT, '0);
    write_register(CFG_RECV_PKT_LIMIT, '0);
    issue(OP_RES_SEND, 64'd3001, 64'd1, 64'd1);
    issue(OP_RES_SEND, 64'd3002, 64'd1, 64'd1);
    issue(OP_RES_RECV, 64'd3003, 64'd1, 64'd1);
    issue(OP_CHECK, 64'd3004, '0, '0);
    issue(OP_RESET_SEND, 64'd3005, '0, '0);
    issue(OP_CHECK, 64'd3006, '0, '0);
    settle();

    // Random phases, each with its own policy and idling, drained at the end.
    clock_ms = 64'd4000;
    for (int p = 0; p < PHASES; p++) begin
      set_policy(p == 0);
      quiet_phase  = ($urandom_range(0, 3) == 0);
      amount_scale = $urandom_range(1, 1000);
      age_step     = $urandom_range(1, 200);
      if ($urandom_range(0, 1) == 1) issue(OP_RESET_ALL, clock_ms, usage_amount(), '0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        issue(pick_op(), pick_now(), usage_amount(), usage_amount());
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (usage_sb.pending() != 0)
      usage_sb.report_mismatch($sformatf("%0d results never arrived", usage_sb.pending()));
    if (usage_sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
